// ===== rtl/fph_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fph_pkg
// Shared types and codes for the fit-policy hole allocator.
// ----------------------------------------------------------------------------
package fph_pkg;

	// item function codes
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_ALLOC = 1'b1;

	// fit policy codes (any other code acts as first fit)
	localparam logic [1:0] MODE_BEST  = 2'd0;
	localparam logic [1:0] MODE_WORST = 2'd1;
	localparam logic [1:0] MODE_FIRST = 2'd2;

	// result status codes
	localparam logic [1:0] ST_LOADED = 2'd0;
	localparam logic [1:0] ST_ALLOC  = 2'd1;
	localparam logic [1:0] ST_NOFIT  = 2'd2;

	// register index (paddr bit 2)
	localparam logic REG_FIT_MODE   = 1'b0;
	localparam logic REG_HOLE_COUNT = 1'b1;

	typedef struct packed {
		logic        func;
		logic [5:0]  hole_index;
		logic [15:0] item_size;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  chosen_hole;
		logic [15:0] size_left;
	} res_t;

	typedef struct packed {
		logic [1:0] fit_mode;
		logic [6:0] hole_count;
	} cfg_t;

endpackage

// ===== rtl/fph_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fph_mem
// Hole size table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fph_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 16,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/fph_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fph_cfg
// APB register file: fit policy and number of holes in use.
// ----------------------------------------------------------------------------
module fph_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	output fph_pkg::cfg_t cfg
);
	import fph_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_FIT_MODE:   cfg_q.fit_mode   <= pwdata[1:0];
				REG_HOLE_COUNT: cfg_q.hole_count <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (paddr[2])
			REG_FIT_MODE:   prdata = {30'd0, cfg_q.fit_mode};
			REG_HOLE_COUNT: prdata = {25'd0, cfg_q.hole_count};
			default:        prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/fph_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fph_ctrl
// Sequencer: clearing pass, hole loads, and the allocate scan with
// read-modify-write of the chosen hole.
// ----------------------------------------------------------------------------
module fph_ctrl #(
	parameter int MAX_HOLES = 64,
	parameter int SIZE_BITS = 16,
	parameter int AW        = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fph_pkg::cfg_t        cfg,
	input  logic                 start,
	input  fph_pkg::cmd_t        cmd,
	output logic                 busy,
	output logic                 done,
	output fph_pkg::res_t        result,
	output logic                 mem_we,
	output logic [AW-1:0]        mem_waddr,
	output logic [SIZE_BITS-1:0] mem_wdata,
	output logic                 mem_re,
	output logic [AW-1:0]        mem_raddr,
	input  logic [SIZE_BITS-1:0] mem_rdata
);
	import fph_pkg::*;

	localparam int CW = AW + 1;

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_SCAN  = 2'd2;

	logic [1:0]           state_q, state_n;
	logic [AW-1:0]        clr_q;
	logic [CW-1:0]        iss_q;
	logic [CW-1:0]        lim_q, lim_n;
	logic                 rd_vld_s1;
	logic [AW-1:0]        rd_idx_s1;
	logic                 found_q;
	logic [AW-1:0]        pick_q;
	logic [SIZE_BITS-1:0] pick_size_q;
	logic [SIZE_BITS-1:0] sz_q;
	logic [1:0]           mode_q;
	logic                 done_q, done_n;
	res_t                 res_q, res_n;
	logic                 hit, take, fin, in_range;
	logic [SIZE_BITS-1:0] remain;
	logic [31:0]          cnt_ext;

	// clamp the hole count to the table depth
	assign cnt_ext = 32'(cfg.hole_count);
	assign lim_n   = (cnt_ext > 32'(MAX_HOLES)) ? CW'(MAX_HOLES) : CW'(cnt_ext);

	assign in_range = 32'(cmd.hole_index) < 32'(MAX_HOLES);

	// compare the returning entry against the request and the current pick
	assign hit  = rd_vld_s1 && (mem_rdata > sz_q);
	assign take = hit && (!found_q
		|| (mode_q == MODE_BEST  && mem_rdata < pick_size_q)
		|| (mode_q == MODE_WORST && mem_rdata > pick_size_q));
	assign fin    = (iss_q == lim_q) && !rd_vld_s1;
	assign remain = pick_size_q - sz_q;

	// next state, memory ports and result
	always_comb begin
		state_n   = state_q;
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = AW'(iss_q);
		done_n    = 1'b0;
		res_n     = '0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				if (clr_q == AW'(MAX_HOLES - 1)) begin
					state_n = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					if (cmd.func == FUNC_LOAD) begin
						done_n            = 1'b1;
						res_n.status      = ST_LOADED;
						res_n.chosen_hole = cmd.hole_index;
						if (in_range) begin
							mem_we          = 1'b1;
							mem_waddr       = AW'(cmd.hole_index);
							mem_wdata       = SIZE_BITS'(cmd.item_size);
							res_n.size_left = 16'(SIZE_BITS'(cmd.item_size));
						end
					end else begin
						state_n = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				mem_re = (iss_q != lim_q);
				if (fin) begin
					done_n  = 1'b1;
					state_n = S_IDLE;
					if (found_q) begin
						mem_we            = 1'b1;
						mem_waddr         = pick_q;
						mem_wdata         = remain;
						res_n.status      = ST_ALLOC;
						res_n.chosen_hole = 6'(pick_q);
						res_n.size_left   = 16'(remain);
					end else begin
						res_n.status = ST_NOFIT;
					end
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			iss_q     <= '0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_n;
			done_q    <= done_n;
			rd_vld_s1 <= mem_re;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == S_IDLE) begin
				iss_q   <= '0;
				found_q <= 1'b0;
			end else if (state_q == S_SCAN) begin
				if (mem_re) begin
					iss_q <= iss_q + 1'b1;
				end
				if (hit) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		res_q     <= res_n;
		rd_idx_s1 <= AW'(iss_q);
		if (state_q == S_IDLE && start) begin
			sz_q   <= SIZE_BITS'(cmd.item_size);
			mode_q <= cfg.fit_mode;
			lim_q  <= lim_n;
		end
		if (take) begin
			pick_q      <= rd_idx_s1;
			pick_size_q <= mem_rdata;
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

endmodule

// ===== rtl/fit_policy_hole_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_policy_hole_allocator
// Table of free hole sizes with best, worst and first fit allocation.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken at a clock edge with start high
//   and busy low. func selects a load (write a hole size at hole_index) or an
//   allocate (find a hole strictly larger than item_size).
//   Result channel: done is high for exactly one cycle with result valid; the
//   receiver cannot stall, so results are never held.
//   Load: result in the next cycle, busy stays low, so loads
//   can be issued every cycle.
//   Allocate: the scan reads one table entry per cycle from the single read
//   port, over the clamped hole count, busy high meanwhile. The chosen entry
//   is rewritten in the final cycle of the scan.
//   Configuration (fit_mode, hole_count) must be written over APB while idle;
//   the block does not enforce this. Reset: control and APB registers clear;
//   a clearing pass zeroes the table one entry a cycle, with busy high.
// ----------------------------------------------------------------------------
module fit_policy_hole_allocator #(
	parameter int MAX_HOLES = 64,
	parameter int SIZE_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready,
	input  logic           start,
	input  fph_pkg::cmd_t  cmd,
	output logic           busy,
	output logic           done,
	output fph_pkg::res_t  result
);
	import fph_pkg::*;

	localparam int AW = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;

	cfg_t                 cfg;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [SIZE_BITS-1:0] mem_wdata;
	logic                 mem_re;
	logic [AW-1:0]        mem_raddr;
	logic [SIZE_BITS-1:0] mem_rdata;

	fph_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fph_mem #(
		.DEPTH (MAX_HOLES),
		.WIDTH (SIZE_BITS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	fph_ctrl #(
		.MAX_HOLES (MAX_HOLES),
		.SIZE_BITS (SIZE_BITS),
		.AW        (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.start     (start),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// a load gives its result in the next cycle
	a_load_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.func == FUNC_LOAD |=> done && result.status == ST_LOADED)
		else $error("load result missing");

	// an allocate occupies the block
	a_alloc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.func == FUNC_ALLOC |=> busy)
		else $error("allocate did not start a scan");

	// a miss reports zero index and size
	a_nofit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == ST_NOFIT |-> result.chosen_hole == 6'd0
			&& result.size_left == 16'd0)
		else $error("miss result not cleared");

	// allocate results only come out of a scan
	a_alloc_scan: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == ST_ALLOC || result.status == ST_NOFIT) |-> $past(busy))
		else $error("allocate result without scan");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the fit-policy hole allocator. Commands go in on the
// start/busy channel and registers are set over APB while the block is idle.
// A scoreboard class keeps its own copy of the hole table and fit settings.
// It works out the result of every accepted command and matches each done
// strobe, in order, against the oldest prediction. A short directed run covers
// each policy, the tie rule, zero and oversized counts and the size extremes.
// Random rounds follow, each with a fresh setting: the holes in use are
// loaded, then requests sized close to those holes are issued, with noise
// mixed in.
// ----------------------------------------------------------------------------
module testbench;

	import fph_pkg::*;

	localparam int TABLE_DEPTH = 64;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int PHASE_ITEMS = 630;

	// reference copy of the allocator, one entry per accepted transaction
	class hole_scoreboard;
		logic [15:0] holes [TABLE_DEPTH];
		logic [1:0]  mode;
		logic [6:0]  count;
		res_t        predicted_outcomes [$];
		int          errors;

		function new();
			foreach (holes[i]) holes[i] = '0;
			mode   = MODE_BEST;
			count  = '0;
			errors = 0;
		endfunction

		function void write_reg(logic idx, logic [31:0] value);
			if (idx == REG_FIT_MODE) mode = value[1:0];
			else count = value[6:0];
		endfunction

		function void apply_command(cmd_t c);
			res_t r;
			int   span;
			int   pick;
			bit   found;
			if (c.func == FUNC_LOAD) begin
				holes[c.hole_index] = c.item_size;
				r.status      = ST_LOADED;
				r.chosen_hole = c.hole_index;
				r.size_left   = c.item_size;
			end else begin
				span  = (count > TABLE_DEPTH) ? TABLE_DEPTH : int'(count);
				found = 1'b0;
				pick  = 0;
				for (int j = 0; j < span; j++) begin
					if (holes[j] > c.item_size) begin
						if (!found) begin
							found = 1'b1;
							pick  = j;
							// first fit, and the spare code that behaves like it
							if (mode != MODE_BEST && mode != MODE_WORST) break;
						end else if (mode == MODE_BEST && holes[j] < holes[pick]) begin
							pick = j;
						end else if (mode == MODE_WORST && holes[j] > holes[pick]) begin
							pick = j;
						end
					end
				end
				if (!found) begin
					r.status      = ST_NOFIT;
					r.chosen_hole = '0;
					r.size_left   = '0;
				end else begin
					holes[pick]   = holes[pick] - c.item_size;
					r.status      = ST_ALLOC;
					r.chosen_hole = pick[5:0];
					r.size_left   = holes[pick];
				end
			end
			predicted_outcomes.push_back(r);
		endfunction

		function void compare_outcome(res_t got);
			res_t want;
			if (predicted_outcomes.size() == 0) begin
				$display("%0t: result with nothing pending, actual %h", $time, got);
				errors++;
				return;
			end
			want = predicted_outcomes.pop_front();
			if (got.status !== want.status) begin
				$display("%0t: status mismatch, expected %0d actual %0d",
					$time, want.status, got.status);
				errors++;
			end
			if (got.chosen_hole !== want.chosen_hole) begin
				$display("%0t: chosen_hole mismatch, expected %0d actual %0d",
					$time, want.chosen_hole, got.chosen_hole);
				errors++;
			end
			if (got.size_left !== want.size_left) begin
				$display("%0t: size_left mismatch, expected %h actual %h",
					$time, want.size_left, got.size_left);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        start;
	cmd_t        cmd;
	logic        busy;
	logic        done;
	res_t        result;

	hole_scoreboard sb;
	int             idle_pct;
	int             issued;
	int             cycles;

	fit_policy_hole_allocator uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.start   (start),
		.cmd     (cmd),
		.busy    (busy),
		.done    (done),
		.result  (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// result monitor: the strobe lasts one cycle and cannot be held off
	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1) sb.compare_outcome(result);
	end

	// one APB write: setup cycle, access cycle, then a bus idle cycle
	task automatic reg_write(logic idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.write_reg(idx, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// hold start until the block takes the transaction, then maybe pause
	task automatic send(logic fn, logic [5:0] idx, logic [15:0] size);
		cmd_t c;
		int   gap;
		c.func       = fn;
		c.hole_index = idx;
		c.item_size  = size;
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy !== 1'b0);
		sb.apply_command(c);
		issued++;
		gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// wait for every predicted result and a quiet block
	task automatic drain();
		start <= 1'b0;
		while (sb.predicted_outcomes.size() != 0 || busy !== 1'b0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_policy(logic [1:0] m, logic [6:0] hc);
		drain();
		reg_write(REG_FIT_MODE, 32'(m));
		reg_write(REG_HOLE_COUNT, 32'(hc));
	endtask

	function automatic logic [15:0] random_size();
		case ($urandom_range(0, 3))
			0: random_size = 16'($urandom_range(0, 15));
			1: random_size = 16'($urandom);
			2: random_size = 16'($urandom_range(65520, 65535));
			default: random_size = 16'($urandom_range(0, 300));
		endcase
	endfunction

	// one random round: new setting, fill the holes in use, then requests
	task automatic random_round();
		logic [1:0]  m;
		logic [6:0]  hc;
		logic [15:0] base;
		logic [15:0] req;
		int          span;
		int          n;
		int          idx;
		m = 2'($urandom_range(0, 3));
		case ($urandom_range(0, 9))
			0: hc = 7'd0;
			1: hc = 7'd64;
			2: hc = 7'($urandom_range(65, 127));
			3: hc = 7'($urandom_range(9, 63));
			default: hc = 7'($urandom_range(1, 8));
		endcase
		set_policy(m, hc);
		span = (hc > TABLE_DEPTH) ? TABLE_DEPTH : int'(hc);
		for (int k = 0; k < span; k++) send(FUNC_LOAD, 6'(k), random_size());
		n = $urandom_range(4, 2 * span + 4);
		for (int k = 0; k < n; k++) begin
			idx  = (span > 0) ? $urandom_range(0, span - 1) : 0;
			base = sb.holes[idx];
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					// requests near a live hole: leaves a sliver, exact size, or a part
					case ($urandom_range(0, 2))
						0: req = (base == 0) ? 16'd0 : base - 16'd1;
						1: req = base;
						default: req = base >> $urandom_range(1, 4);
					endcase
					send(FUNC_ALLOC, 6'($urandom), req);
				end
				6: send(FUNC_ALLOC, 6'($urandom), 16'($urandom));
				7: send(FUNC_ALLOC, 6'($urandom), 16'd0);
				8: send(FUNC_LOAD, 6'($urandom), random_size());
				default: send(FUNC_ALLOC, 6'($urandom), 16'hFFFF);
			endcase
		end
	endtask

	initial begin
		sb       = new();
		idle_pct = 26;
		issued   = 0;
		cycles   <= 0;
		arst_n   <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		start    <= 1'b0;
		cmd      <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// clearing pass keeps busy high; drain covers it
		drain();

		// directed: empty count after reset, then each policy and the tie rule
		send(FUNC_ALLOC, 6'd0, 16'd0);
		set_policy(MODE_BEST, 7'd4);
		send(FUNC_LOAD, 6'd0, 16'd100);
		send(FUNC_LOAD, 6'd1, 16'd50);
		send(FUNC_LOAD, 6'd2, 16'd50);
		send(FUNC_LOAD, 6'd3, 16'hFFFF);
		send(FUNC_ALLOC, 6'd0, 16'd49);
		send(FUNC_ALLOC, 6'd0, 16'hFFFF);
		set_policy(MODE_WORST, 7'd4);
		send(FUNC_ALLOC, 6'd0, 16'd10);
		set_policy(MODE_FIRST, 7'd4);
		send(FUNC_ALLOC, 6'd0, 16'd60);
		// spare mode code behaves as first fit
		set_policy(2'd3, 7'd4);
		send(FUNC_ALLOC, 6'd0, 16'd45);
		// count beyond the table is clamped
		set_policy(MODE_WORST, 7'd127);
		send(FUNC_LOAD, 6'd63, 16'hFFFF);
		send(FUNC_LOAD, 6'd42, 16'h8000);
		send(FUNC_ALLOC, 6'd63, 16'hFFFE);
		send(FUNC_ALLOC, 6'd21, 16'h7FFF);
		set_policy(MODE_BEST, 7'd64);
		send(FUNC_ALLOC, 6'd0, 16'd0);
		send(FUNC_LOAD, 6'd0, 16'd0);
		set_policy(MODE_BEST, 7'd1);
		send(FUNC_ALLOC, 6'd0, 16'd0);

		// random rounds: sender idles often, then mostly, then never
		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 26 : (ph == 1) ? 78 : 0;
			issued   = 0;
			while (issued < PHASE_ITEMS) random_round();
		end

		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.predicted_outcomes.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
